FILE: hdl/cnr_pkg.sv
// Package with widths, reset values and status codes of the cubic root finder.
`timescale 1ns / 1ps
`default_nettype none
package cnr_pkg;
  localparam int unsigned TolW = 31;
  localparam int unsigned IterW = 20;
  localparam int unsigned DataW = 32;
  localparam logic [TolW-1:0] TolReset = 31'd66;
  localparam logic [IterW-1:0] IterReset = 20'd1000000;
  localparam logic [1:0] StatConverged = 2'd0;
  localparam logic [1:0] StatLimit = 2'd1;
  localparam logic [1:0] StatFlat = 2'd2;
  localparam logic RegTol = 1'b0;
  localparam logic RegIter = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/cubic_newton_root_top.sv
// Newton-Raphson root finder for a Q16.16 cubic, one shared multiplier and a radix-2 divider.
// A word whose f(x0) already meets the tolerance goes to the output after one evaluation and compare;
// each Newton update adds five multiplies on the shared multiplier, 64 restoring divide steps,
// one step to apply the quotient and one compare.
// One word at a time; s_axis_tready is high while idle, also while a result waits to leave.
// Reset is asynchronous and active low; tolerance returns to 66 and the limit to 1000000.
`timescale 1ns / 1ps
`default_nettype none
module cubic_newton_root_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_index_i,
  input  wire logic [30:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // coef_cubic, coef_square, coef_linear, coef_constant, start_estimate
  input  wire logic [159:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // root_estimate, iteration_count, status, 2 zero bits
  output logic [55:0]       m_axis_tdata
);
  localparam logic [3:0] SIdle = 4'd0, SF1 = 4'd1, SF2 = 4'd2, SF3 = 4'd3, SChk = 4'd4,
                         SD1 = 4'd5, SD2 = 4'd6, SDiv = 4'd7, SOut = 4'd8;

  logic [3:0] st_q, st_d;
  logic [30:0] tol_q;
  logic [19:0] lim_q, cnt_q, cnt_d;
  logic signed [31:0] a_q, b_q, c_q, d_q, x_q, x_d, f_q, f_d, t_q, t_d;
  logic signed [63:0] prod_q;
  logic mph_q, mph_d;
  logic [1:0] stat_q, stat_d;
  logic [63:0] rem_q, rem_d, quo_q, quo_d, num_q, num_d;
  logic [31:0] den_q, den_d;
  logic qneg_q, qneg_d;
  logic [6:0] dc_q, dc_d;
  logic obusy_q;
  logic [55:0] odata_q;
  logic signed [31:0] mul_x, mul_y;
  logic signed [47:0] mfl;
  logic signed [63:0] qs, xsub;
  logic [63:0] rsh;
  logic [31:0] fabs;
  logic [63:0] fnum;

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign mfl = prod_q[63:16];
  assign fabs = f_q[31] ? 32'(-{f_q[31], f_q}) : 32'(f_q);
  assign fnum = f_q[31] ? 64'(-(64'(f_q) <<< 16)) : 64'(f_q) << 16;
  assign rsh = {rem_q[62:0], num_q[63]};
  assign qs = qneg_q ? -$signed(quo_q) : $signed(quo_q);
  assign xsub = 64'(x_q) - qs;

  always_comb begin
    mul_x = x_q;
    mul_y = t_q;
    if (st_q == SD1) begin
      mul_y = a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_x) * 64'(mul_y);
  end

  always_comb begin
    st_d = st_q; x_d = x_q; f_d = f_q; t_d = t_q; cnt_d = cnt_q; stat_d = stat_q;
    mph_d = 1'b0; rem_d = rem_q; quo_d = quo_q; num_d = num_q; den_d = den_q;
    qneg_d = qneg_q; dc_d = dc_q;
    case (st_q)
      SIdle: begin
        if (s_axis_tvalid) begin
          x_d = $signed(s_axis_tdata[159:128]);
          t_d = $signed(s_axis_tdata[31:0]);
          cnt_d = '0;
          st_d = SF1;
        end
      end
      SF1, SF2, SF3: begin
        mph_d = ~mph_q;
        if (mph_q) begin
          mph_d = 1'b0;
          if (st_q == SF1) begin
            t_d = sat(64'(b_q) + 64'(mfl)); st_d = SF2;
          end else if (st_q == SF2) begin
            t_d = sat(64'(c_q) + 64'(mfl)); st_d = SF3;
          end else begin
            f_d = sat(64'(d_q) + 64'(mfl)); st_d = SChk;
          end
        end
      end
      SChk: begin
        if ({1'b0, fabs} <= {2'b0, tol_q}) begin
          stat_d = cnr_pkg::StatConverged; st_d = SOut;
        end else if (cnt_q >= lim_q) begin
          stat_d = cnr_pkg::StatLimit; st_d = SOut;
        end else begin
          st_d = SD1;
        end
      end
      SD1: begin
        mph_d = ~mph_q;
        if (mph_q) begin
          mph_d = 1'b0;
          t_d = sat(64'(b_q) * 2 + 64'(sat(64'(mfl))) * 3);
          st_d = SD2;
        end
      end
      SD2: begin
        mph_d = ~mph_q;
        if (mph_q) begin
          mph_d = 1'b0;
          den_d = 32'(sat(64'(c_q) + 64'(mfl)));
          if (den_d == 32'd0) begin
            stat_d = cnr_pkg::StatFlat; st_d = SOut;
          end else begin
            qneg_d = f_q[31] ^ den_d[31];
            if (den_d[31]) den_d = -den_d;
            num_d = fnum; rem_d = '0; quo_d = '0; dc_d = '0;
            st_d = SDiv;
          end
        end
      end
      SDiv: begin
        if (dc_q[6]) begin
          x_d = sat(xsub);
          t_d = a_q;
          cnt_d = cnt_q + 20'd1;
          st_d = SF1;
        end else begin
          num_d = num_q << 1;
          if (rsh >= 64'(den_q)) begin
            rem_d = rsh - 64'(den_q); quo_d = {quo_q[62:0], 1'b1};
          end else begin
            rem_d = rsh; quo_d = {quo_q[62:0], 1'b0};
          end
          dc_d = dc_q + 7'd1;
        end
      end
      SOut: begin
        if (!obusy_q || m_axis_tready) st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  assign s_axis_tready = (st_q == SIdle);
  assign m_axis_tvalid = obusy_q;
  assign m_axis_tdata = odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; mph_q <= 1'b0; obusy_q <= 1'b0;
      tol_q <= cnr_pkg::TolReset; lim_q <= cnr_pkg::IterReset;
    end else begin
      st_q <= st_d; mph_q <= mph_d;
      if (cfg_we_i && cfg_index_i == cnr_pkg::RegTol) tol_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == cnr_pkg::RegIter) lim_q <= cfg_data_i[19:0];
      if (st_q == SOut && (!obusy_q || m_axis_tready)) obusy_q <= 1'b1;
      else if (m_axis_tready) obusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; f_q <= f_d; t_q <= t_d; cnt_q <= cnt_d; stat_q <= stat_d;
    rem_q <= rem_d; quo_q <= quo_d; num_q <= num_d; den_q <= den_d;
    qneg_q <= qneg_d; dc_q <= dc_d;
    if (s_axis_tvalid && s_axis_tready) begin
      a_q <= $signed(s_axis_tdata[31:0]);
      b_q <= $signed(s_axis_tdata[63:32]);
      c_q <= $signed(s_axis_tdata[95:64]);
      d_q <= $signed(s_axis_tdata[127:96]);
    end
    if (st_q == SOut && (!obusy_q || m_axis_tready)) begin
      odata_q <= {2'b00, stat_q, cnt_q, x_q};
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> st_q == SIdle) else $error("ready outside idle");
  a_cnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SChk |-> cnt_q <= lim_q) else $error("count exceeds limit");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[53:52] != 2'd3) else $error("bad status");
`endif
endmodule
`default_nettype wire
